// ===== rtl/core/key_group_debounce_events_core_macros.svh =====
// assertion macros for the key group debounce core
`ifndef KEY_GROUP_DEBOUNCE_EVENTS_CORE_MACROS_SVH
`define KEY_GROUP_DEBOUNCE_EVENTS_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KGDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define KGDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kgde_pkg.sv =====
// shared constants, types and helpers for the key group debounce core
`default_nettype none

package kgde_pkg;

  localparam int KEY_COUNT = 8;
  localparam int IDX_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CNT_W     = 8;
  localparam int ACT_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_KEYS  = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0]     SETTLE_RESET = CNT_W'(10);
  localparam logic [ACT_W-1:0]     ACTIVE_RESET = ACT_W'(8);
  localparam logic [CNT_W-1:0]     CNT_MAX      = {CNT_W{1'b1}};

  typedef struct packed {
    logic diff;
    logic level;
    logic down;
  } lane_t;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic                 last;
    logic [KEY_COUNT-1:0] onehot;
  } pick_t;

  function automatic logic [KEY_COUNT-1:0] key_mask(input logic [ACT_W-1:0] n);
    logic [KEY_COUNT-1:0] m;
    for (int i = 0; i < KEY_COUNT; i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kgde_lane.sv =====
// per-key lane: change detect, next accepted level and pressed flag
`default_nettype none

module kgde_lane
  import kgde_pkg::*;
(
  input  wire logic  sample,
  input  wire logic  accepted,
  input  wire logic  enable,
  output lane_t      lane
);

  always_comb begin
    lane.diff  = (sample ^ accepted) & enable;
    lane.level = enable ? sample : accepted;
    lane.down  = ~lane.level & enable;
  end

endmodule

`default_nettype wire

// ===== rtl/core/kgde_merge.sv =====
// merge stage: picks the lowest pending key event
`default_nettype none

module kgde_merge
  import kgde_pkg::*;
(
  input  wire logic [KEY_COUNT-1:0] pending,
  output pick_t                     pick
);

  logic [KEY_COUNT-1:0] low_bit;
  logic [IDX_W-1:0]     idx;

  always_comb begin
    low_bit = pending & (~pending + KEY_COUNT'(1));
    idx     = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      idx = idx | (low_bit[i] ? IDX_W'(i) : '0);
    end
    pick.idx    = idx;
    pick.onehot = low_bit;
    pick.last   = ((pending & ~low_bit) == '0);
  end

endmodule

`default_nettype wire

// ===== rtl/core/key_group_debounce_events_core.sv =====
// top level of the key group debounce core with per-key change events
//
// input channel: one request per millisecond tick, in_pin_levels holds the
// sampled key levels (0 = pressed); in_valid/in_stall handshake
// output channel: one request per changed key, lowest index first, with
// out_key_index, out_key_released, out_last_event and out_down_mask
// config channel: cfg_valid/cfg_ready, index 0 settle_ticks, 1 active_keys;
// cfg_ready is always high, write only while idle
// a tick that settles a change loads every changed key into the event queue;
// the queued events then move into the output register, lowest key first,
// one per cycle while the receiver does not stall
// a tick that causes no event leaves the input free for the next tick
// the input stalls only while events of the previous tick are still queued;
// the output register lets a new tick in while the last event waits
// when the receiver stalls, the output holds and the queue waits
// reset: all keys released, counter zero, settle 10, active keys 8
`default_nettype none

module key_group_debounce_events_core
  import kgde_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire logic [KEY_COUNT-1:0] in_pin_levels,
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      logic [IDX_W-1:0]     out_key_index,
  output      logic                 out_key_released,
  output      logic                 out_last_event,
  output      logic [KEY_COUNT-1:0] out_down_mask,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  `include "key_group_debounce_events_core_macros.svh"

  logic [CNT_W-1:0]     settle_r;
  logic [ACT_W-1:0]     active_r;
  logic [KEY_COUNT-1:0] accepted_r, accepted_nxt;
  logic [CNT_W-1:0]     elapsed_r, elapsed_nxt;
  logic [KEY_COUNT-1:0] pending_r, pending_nxt;
  logic [KEY_COUNT-1:0] down_r, down_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r;
  logic                 out_rel_r;
  logic                 out_last_r;
  logic [KEY_COUNT-1:0] out_down_r;

  logic [KEY_COUNT-1:0] mask;
  lane_t                lanes [KEY_COUNT];
  logic [KEY_COUNT-1:0] diff_vec, level_vec, down_vec;
  logic [CNT_W-1:0]     elapsed_inc;
  logic                 tick, load;
  pick_t                pick;

  assign mask = key_mask(active_r);

  for (genvar g = 0; g < KEY_COUNT; g++) begin : g_lane
    kgde_lane u_lane (
      .sample   (in_pin_levels[g]),
      .accepted (accepted_r[g]),
      .enable   (mask[g]),
      .lane     (lanes[g])
    );
    assign diff_vec[g]  = lanes[g].diff;
    assign level_vec[g] = lanes[g].level;
    assign down_vec[g]  = lanes[g].down;
  end

  kgde_merge u_merge (
    .pending (pending_r),
    .pick    (pick)
  );

  assign in_stall  = (pending_r != '0);
  assign cfg_ready = 1'b1;
  assign tick      = in_valid && !in_stall;
  assign load      = (pending_r != '0) && (!out_valid_r || !out_stall);

  assign elapsed_inc = (elapsed_r == CNT_MAX) ? elapsed_r : elapsed_r + CNT_W'(1);

  always_comb begin
    accepted_nxt = accepted_r;
    elapsed_nxt  = elapsed_r;
    pending_nxt  = pending_r;
    down_nxt     = down_r;
    if (load) begin
      pending_nxt = pending_r & ~pick.onehot;
    end
    if (tick) begin
      if (diff_vec == '0) begin
        elapsed_nxt = '0;
      end else if (elapsed_inc < settle_r) begin
        elapsed_nxt = elapsed_inc;
      end else begin
        elapsed_nxt  = '0;
        accepted_nxt = level_vec;
        pending_nxt  = diff_vec;
        down_nxt     = down_vec;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r    <= SETTLE_RESET;
      active_r    <= ACTIVE_RESET;
      accepted_r  <= '1;
      elapsed_r   <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SETTLE_TICKS: settle_r <= cfg_data[CNT_W-1:0];
          REG_ACTIVE_KEYS:  active_r <= cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      accepted_r  <= accepted_nxt;
      elapsed_r   <= elapsed_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    down_r <= down_nxt;
    if (load) begin
      out_idx_r  <= pick.idx;
      out_rel_r  <= accepted_r[pick.idx];
      out_last_r <= pick.last;
      out_down_r <= down_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_key_index    = out_idx_r;
  assign out_key_released = out_rel_r;
  assign out_last_event   = out_last_r;
  assign out_down_mask    = out_down_r;

  `KGDE_ASSERT_NEXT(a_one_event_per_load, load,
    $countones(pending_r) == $countones($past(pending_r)) - 1,
    "event queue did not drop exactly one key")
  `KGDE_ASSERT_NEXT(a_last_empties_queue, load && pick.last, pending_r == '0,
    "last event loaded but keys still queued")
  `KGDE_ASSERT_NOW(a_pending_in_use, pending_r != '0, (pending_r & ~mask) == '0,
    "queued event for a key that is not in use")

endmodule

`default_nettype wire
